FILE: src/text_mode_screen_writer_top_defines.svh
// Assertion macros used by the screen writer back part (tmsw_back).
// Each macro expects clk_i and rst_ni to be in scope.
`ifndef TEXT_MODE_SCREEN_WRITER_TOP_DEFINES_SVH
`define TEXT_MODE_SCREEN_WRITER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tmsw_pkg.sv
`default_nettype none

package tmsw_pkg;

  // Field widths of the command and result beats.
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int DATA_W  = 16;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int ATTR_W  = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

  // Attribute after reset and the register map.
  localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'd140;
  localparam int                PADDR_W        = 3;
  localparam logic [PADDR_W-1:0] ADDR_ATTRIBUTE = 3'd0;

  // Operation kinds handed from the front to the back.
  typedef enum logic [2:0] {
    OP_GLYPH,
    OP_NEWLINE,
    OP_TAB,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                kind;
    logic [CHAR_W-1:0]  ch;
    logic               in_range;
    logic [INDEX_W-1:0] index;
  } op_t;

  // Status reported by the back part.
  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

`default_nettype wire

FILE: src/tmsw_cmd_if.sv
`default_nettype none

// Command channel: one beat per command.
interface tmsw_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tmsw_pkg::CMD_W-1:0]   command;
  logic [tmsw_pkg::CHAR_W-1:0]  character;
  logic [tmsw_pkg::INDEX_W-1:0] cell_index;

  modport source (output valid, command, character, cell_index, input ready);
  modport sink   (input valid, command, character, cell_index, output ready);
endinterface

`default_nettype wire

FILE: src/tmsw_res_if.sv
`default_nettype none

// Result channel: one beat per command.
interface tmsw_res_if;
  logic                        valid;
  logic                        ready;
  logic [tmsw_pkg::DATA_W-1:0] cell_data;
  logic [tmsw_pkg::COL_W-1:0]  cursor_column;
  logic [tmsw_pkg::ROW_W-1:0]  cursor_row;

  modport source (output valid, cell_data, cursor_column, cursor_row, input ready);
  modport sink   (input valid, cell_data, cursor_column, cursor_row, output ready);
endinterface

`default_nettype wire

FILE: src/tmsw_front.sv
`default_nettype none

// Front part: takes command beats and turns them into back-end operations.
module tmsw_front #(
  parameter int unsigned CELL_COUNT = 2000
) (
  input  logic            enable_i,
  tmsw_cmd_if.sink        cmd_i,
  output logic            op_valid_o,
  output tmsw_pkg::op_t   op_o,
  input  logic            op_ready_i
);

  // Beats pass only when the back is not sweeping after reset.
  assign cmd_i.ready = enable_i && op_ready_i;
  assign op_valid_o  = enable_i && cmd_i.valid;

  // Classify the command and the character it carries.
  always_comb begin
    op_o.ch       = cmd_i.character;
    op_o.index    = cmd_i.cell_index;
    op_o.in_range = (32'(cmd_i.cell_index) < CELL_COUNT);
    unique case (cmd_i.command)
      tmsw_pkg::CMD_PUT: begin
        priority if (cmd_i.character == tmsw_pkg::CHAR_NEWLINE) begin
          op_o.kind = tmsw_pkg::OP_NEWLINE;
        end else if (cmd_i.character == tmsw_pkg::CHAR_TAB) begin
          op_o.kind = tmsw_pkg::OP_TAB;
        end else begin
          op_o.kind = tmsw_pkg::OP_GLYPH;
        end
      end
      tmsw_pkg::CMD_READ: begin
        op_o.kind = tmsw_pkg::OP_READ;
      end
      tmsw_pkg::CMD_CLEAR: begin
        op_o.kind = tmsw_pkg::OP_CLEAR;
      end
      default: begin
        op_o.kind = tmsw_pkg::OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/tmsw_queue.sv
`default_nettype none

// Two-entry operation queue between the front and the back.
module tmsw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tmsw_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tmsw_pkg::op_t pop_op_o
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tmsw_pkg::op_t    entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/tmsw_back.sv
`default_nettype none
`include "text_mode_screen_writer_top_defines.svh"

// Back part: owns the screen memory and the cursor and runs operations.
module tmsw_back #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tmsw_pkg::ATTR_W-1:0]   attribute_i,
  input  logic                          head_valid_i,
  input  tmsw_pkg::op_t                 head_op_i,
  output logic                          pop_o,
  output tmsw_pkg::back_status_t        status_o,
  tmsw_res_if.source                    res_o
);

  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CCOL_W = $clog2(COLUMNS);
  localparam int CROW_W = $clog2(ROWS);
  localparam int TAB_W  = $clog2(TAB_STOP);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_SWEEP  = 2'd3;

  logic [1:0]                  state_q, state_d;
  tmsw_pkg::op_t               op_q, op_d;
  logic [CCOL_W-1:0]           col_q, col_d;
  logic [CROW_W-1:0]           row_q, row_d;
  logic [TAB_W-1:0]            phase_q, phase_d;
  logic [ADDR_W-1:0]           lin_q, lin_d;
  logic [ADDR_W-1:0]           sweep_addr_q, sweep_addr_d;
  logic [tmsw_pkg::ATTR_W-1:0] fill_attr_q, fill_attr_d;
  logic                        sweep_init_q, sweep_init_d;

  logic                        out_valid_q, out_valid_d;
  logic [tmsw_pkg::DATA_W-1:0] out_data_q, out_data_d;
  logic [tmsw_pkg::COL_W-1:0]  out_col_q, out_col_d;
  logic [tmsw_pkg::ROW_W-1:0]  out_row_q, out_row_d;

  logic [CCOL_W-1:0]           adv_col;
  logic [CROW_W-1:0]           adv_row;
  logic [TAB_W-1:0]            adv_phase;
  logic [ADDR_W-1:0]           adv_lin;
  logic                        last_col, last_row;
  logic                        out_free, load_out;

  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr, mem_raddr;
  logic [tmsw_pkg::DATA_W-1:0] mem_wdata, rdata_q;
  logic [tmsw_pkg::DATA_W-1:0] screen_mem [CELL_COUNT];

  assign status_o.init_busy = sweep_init_q;
  assign out_free           = !out_valid_q || res_o.ready;

  // Cursor position after one written cell.
  always_comb begin
    last_col = (col_q == CCOL_W'(COLUMNS - 1));
    last_row = (row_q == CROW_W'(ROWS - 1));
    adv_col  = last_col ? '0 : col_q + 1'b1;
    adv_row  = last_col ? (last_row ? '0 : row_q + 1'b1) : row_q;
    adv_lin  = (last_col && last_row) ? '0 : lin_q + 1'b1;
    if (last_col || (phase_q == TAB_W'(TAB_STOP - 1))) begin
      adv_phase = '0;
    end else begin
      adv_phase = phase_q + 1'b1;
    end
  end

  // Operation sequencer.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    col_d        = col_q;
    row_d        = row_q;
    phase_d      = phase_q;
    lin_d        = lin_q;
    sweep_addr_d = sweep_addr_q;
    fill_attr_d  = fill_attr_q;
    sweep_init_d = sweep_init_q;
    pop_o        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = lin_q;
    mem_wdata    = {attribute_i, tmsw_pkg::CHAR_SPACE};
    load_out     = 1'b0;
    out_data_d   = '0;
    out_col_d    = tmsw_pkg::COL_W'(col_q);
    out_row_d    = tmsw_pkg::ROW_W'(row_q);
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          op_d  = head_op_i;
          unique case (head_op_i.kind)
            tmsw_pkg::OP_GLYPH, tmsw_pkg::OP_NEWLINE, tmsw_pkg::OP_TAB: begin
              state_d = ST_EXEC;
            end
            tmsw_pkg::OP_CLEAR: begin
              sweep_addr_d = '0;
              fill_attr_d  = attribute_i;
              sweep_init_d = 1'b0;
              state_d      = ST_SWEEP;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_EXEC: begin
        // One cell per cycle; newline and tab repeat until their stop column.
        mem_we = 1'b1;
        if (op_q.kind == tmsw_pkg::OP_GLYPH) begin
          mem_wdata = {attribute_i, op_q.ch};
        end
        col_d   = adv_col;
        row_d   = adv_row;
        phase_d = adv_phase;
        lin_d   = adv_lin;
        if ((op_q.kind == tmsw_pkg::OP_GLYPH) ||
            ((op_q.kind == tmsw_pkg::OP_NEWLINE) && (adv_col == '0)) ||
            ((op_q.kind == tmsw_pkg::OP_TAB) && (adv_phase == '0))) begin
          if (out_free) begin
            load_out  = 1'b1;
            out_col_d = tmsw_pkg::COL_W'(adv_col);
            out_row_d = tmsw_pkg::ROW_W'(adv_row);
            state_d   = ST_IDLE;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          if ((op_q.kind == tmsw_pkg::OP_READ) && op_q.in_range) begin
            out_data_d = rdata_q;
          end
          state_d = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        // Fill the whole screen with blanks, one cell per cycle.
        mem_we       = 1'b1;
        mem_waddr    = sweep_addr_q;
        mem_wdata    = {fill_attr_q, tmsw_pkg::CHAR_SPACE};
        sweep_addr_d = sweep_addr_q + 1'b1;
        if (sweep_addr_q == ADDR_W'(CELL_COUNT - 1)) begin
          if (sweep_init_q) begin
            sweep_init_d = 1'b0;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state; reset starts the blanking sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      col_q        <= '0;
      row_q        <= '0;
      phase_q      <= '0;
      lin_q        <= '0;
      sweep_addr_q <= '0;
      fill_attr_q  <= tmsw_pkg::RESET_ATTR;
      sweep_init_q <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      phase_q      <= phase_d;
      lin_q        <= lin_d;
      sweep_addr_q <= sweep_addr_d;
      fill_attr_q  <= fill_attr_d;
      sweep_init_q <= sweep_init_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Operation and result payload.
  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    if (load_out) begin
      out_data_q <= out_data_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
    end
  end

  // Screen memory: one write port, one registered read port.
  assign mem_raddr = (state_q == ST_IDLE) ? ADDR_W'(head_op_i.index) : ADDR_W'(op_q.index);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= screen_mem[mem_raddr];
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.cell_data     = out_data_q;
  assign res_o.cursor_column = out_col_q;
  assign res_o.cursor_row    = out_row_q;

  // Checks on the sequencer and cursor bookkeeping.
  `TMSW_ASSERT_IMP(a_no_result_in_init, sweep_init_q, !out_valid_q,
                   "result produced during reset sweep")
  `TMSW_ASSERT_IMP(a_cursor_in_range, 1'b1,
                   (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS),
                   "cursor out of range")
  `TMSW_ASSERT_IMP(a_linear_addr, 1'b1,
                   32'(lin_q) == (32'(row_q) * COLUMNS + 32'(col_q)),
                   "linear cursor address out of step with row and column")
  `TMSW_ASSERT_NXT(a_read_to_finish,
                   (state_q == ST_IDLE) && head_valid_i &&
                   (head_op_i.kind == tmsw_pkg::OP_READ),
                   state_q == ST_FINISH,
                   "read did not reach the finish step")

endmodule

`default_nettype wire

FILE: src/text_mode_screen_writer_top.sv
// Channel    Dir  Payload                                       Handshake
// cmd_i      in   command, character, cell_index                valid/ready
// res_o      out  cell_data, cursor_column, cursor_row          valid/ready
// apb        in   psel, penable, pwrite, paddr, pwdata / prdata pready
//
// A put writes one cell, a tab fills blanks up to the next tab stop, a newline
// up to the end of the row and a clear every cell, one cell per cycle
// through the single write port of the screen memory.
// After reset all COLUMNS * ROWS cells (2000 by default) are blanked with
// cmd_i.ready low; register writes are taken meanwhile.
// A two-entry queue lets commands arrive while a result beat is stalled.
`default_nettype none

module text_mode_screen_writer_top #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tmsw_cmd_if.sink                       cmd_i,
  tmsw_res_if.source                     res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tmsw_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [tmsw_pkg::ATTR_W-1:0] attr_q, attr_d;
  logic                        attr_sel;
  logic                        q_push_valid, q_push_ready;
  logic                        q_pop_valid, q_pop;
  tmsw_pkg::op_t               q_push_op, q_pop_op;
  tmsw_pkg::back_status_t      back_status;

  // Attribute register on the APB port.
  assign pready   = 1'b1;
  assign attr_sel = (paddr[2] == tmsw_pkg::ADDR_ATTRIBUTE[2]);
  assign prdata   = attr_sel ? {24'b0, attr_q} : 32'b0;

  always_comb begin
    attr_d = attr_q;
    if (psel && penable && pwrite && attr_sel) begin
      attr_d = pwdata[tmsw_pkg::ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tmsw_pkg::RESET_ATTR;
    end else begin
      attr_q <= attr_d;
    end
  end

  // Front: classify incoming command beats.
  tmsw_front #(
    .CELL_COUNT (COLUMNS * ROWS)
  ) u_front (
    .enable_i   (!back_status.init_busy),
    .cmd_i      (cmd_i),
    .op_valid_o (q_push_valid),
    .op_o       (q_push_op),
    .op_ready_i (q_push_ready)
  );

  // Queue between front and back.
  tmsw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_op_i    (q_push_op),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop),
    .pop_op_o     (q_pop_op)
  );

  // Back: screen memory, cursor and result register.
  tmsw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .attribute_i  (attr_q),
    .head_valid_i (q_pop_valid),
    .head_op_i    (q_pop_op),
    .pop_o        (q_pop),
    .status_o     (back_status),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire
